[src/rotenc_pkg.sv]
// ----------------------------------------------------------------------------
// rotenc_pkg: shared types, codes and the quadrature table
// Word layouts of both channels, event codes, phase codes and the lookup of
// the seven-state detent table used by the phase tracker.
// ----------------------------------------------------------------------------
package rotenc_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;
    localparam int CFG_WIDTH           = 16;
    localparam int CFG_INDEX_WIDTH     = 1;
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd4;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE   = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 1'd1;

    // item kinds
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_CONSUME = 1'b1;

    // event codes
    localparam logic [1:0] EV_IDLE = 2'd0;
    localparam logic [1:0] EV_CW   = 2'd1;
    localparam logic [1:0] EV_CCW  = 2'd2;
    localparam logic [1:0] EV_PUSH = 2'd3;

    // phase codes
    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_CW_FINAL  = 3'd1;
    localparam logic [2:0] PH_CW_BEGIN  = 3'd2;
    localparam logic [2:0] PH_CW_NEXT   = 3'd3;
    localparam logic [2:0] PH_CCW_BEGIN = 3'd4;
    localparam logic [2:0] PH_CCW_FINAL = 3'd5;
    localparam logic [2:0] PH_CCW_NEXT  = 3'd6;

    typedef struct packed {
        logic mode;
        logic pin_a;
        logic pin_b;
        logic pin_push;
    } in_word_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic       clean_a;
        logic       clean_b;
        logic       clean_push;
    } out_word_t;

    // one step of work handed to the trackers
    typedef struct packed {
        logic tick;
        logic consume;
    } step_ctl_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] ev;
    } quad_entry_t;

    // column = A | (B << 1)
    function automatic quad_entry_t quad_lookup(input logic [2:0] phase, input logic [1:0] col);
        quad_entry_t e;
        e.phase = PH_START;
        e.ev    = EV_IDLE;
        case (phase)
            PH_START:
                case (col)
                    2'd1:    e.phase = PH_CW_BEGIN;
                    2'd2:    e.phase = PH_CCW_BEGIN;
                    default: e.phase = PH_START;
                endcase
            PH_CW_FINAL:
                case (col)
                    2'd0:    e.phase = PH_CW_NEXT;
                    2'd2:    e.phase = PH_CW_FINAL;
                    2'd3:    e.ev    = EV_CW;
                    default: e.phase = PH_START;
                endcase
            PH_CW_BEGIN:
                case (col)
                    2'd0:    e.phase = PH_CW_NEXT;
                    2'd1:    e.phase = PH_CW_BEGIN;
                    default: e.phase = PH_START;
                endcase
            PH_CW_NEXT:
                case (col)
                    2'd0:    e.phase = PH_CW_NEXT;
                    2'd1:    e.phase = PH_CW_BEGIN;
                    2'd2:    e.phase = PH_CW_FINAL;
                    default: e.phase = PH_START;
                endcase
            PH_CCW_BEGIN:
                case (col)
                    2'd0:    e.phase = PH_CCW_NEXT;
                    2'd2:    e.phase = PH_CCW_BEGIN;
                    default: e.phase = PH_START;
                endcase
            PH_CCW_FINAL:
                case (col)
                    2'd0:    e.phase = PH_CCW_NEXT;
                    2'd1:    e.phase = PH_CCW_FINAL;
                    2'd3:    e.ev    = EV_CCW;
                    default: e.phase = PH_START;
                endcase
            PH_CCW_NEXT:
                case (col)
                    2'd0:    e.phase = PH_CCW_NEXT;
                    2'd1:    e.phase = PH_CCW_FINAL;
                    2'd2:    e.phase = PH_CCW_BEGIN;
                    default: e.phase = PH_START;
                endcase
            default:
                e.phase = PH_START;
        endcase
        return e;
    endfunction

endpackage

[src/rotenc_debounce.sv]
// ----------------------------------------------------------------------------
// rotenc_debounce: one pin debouncer
// Down counter that reloads while the raw level matches the clean level and
// flips the clean level once it has run out on a differing tick.
// ----------------------------------------------------------------------------
module rotenc_debounce #(
    parameter int TIMER_WIDTH = rotenc_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick,
    input  logic                   raw,
    input  logic [TIMER_WIDTH-1:0] reload,
    output logic                   clean_next
);

    logic [TIMER_WIDTH-1:0] timer_reg;
    logic [TIMER_WIDTH-1:0] timer_next;
    logic                   clean_reg;

    always_comb
    begin
        timer_next = timer_reg;
        clean_next = clean_reg;
        if (tick)
        begin
            if (raw == clean_reg)
            begin
                timer_next = reload;
            end
            else if (timer_reg == '0)
            begin
                clean_next = raw;
                timer_next = reload;
            end
            else
            begin
                timer_next = timer_reg - TIMER_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= TIMER_WIDTH'(rotenc_pkg::DEBOUNCE_RESET);
            clean_reg <= 1'b0;
        end
        else
        begin
            timer_reg <= timer_next;
            clean_reg <= clean_next;
        end
    end

endmodule

[src/rotenc_quad.sv]
// ----------------------------------------------------------------------------
// rotenc_quad: detent phase tracker and pending event latch
// Steps the quadrature table on clean A/B, latches push or rotation events
// and hands the pending event out on a consume.
// ----------------------------------------------------------------------------
module rotenc_quad (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rotenc_pkg::step_ctl_t ctl,
    input  logic                  clean_a,
    input  logic                  clean_b,
    input  logic                  clean_push,
    output logic [1:0]            pending
);

    logic [2:0]              phase_reg;
    logic [2:0]              phase_next;
    logic [1:0]              pending_reg;
    logic [1:0]              pending_next;
    rotenc_pkg::quad_entry_t entry;

    assign entry   = rotenc_pkg::quad_lookup(phase_reg, {clean_b, clean_a});
    assign pending = pending_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        if (ctl.consume)
        begin
            pending_next = rotenc_pkg::EV_IDLE;
        end
        else if (ctl.tick)
        begin
            if (clean_push)
            begin
                pending_next = rotenc_pkg::EV_PUSH;
            end
            phase_next = entry.phase;
            // drop a rotation while something is pending
            if (pending_next == rotenc_pkg::EV_IDLE)
            begin
                pending_next = entry.ev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= rotenc_pkg::PH_START;
            pending_reg <= rotenc_pkg::EV_IDLE;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

endmodule

[src/rotary_encoder_decoder.sv]
// ----------------------------------------------------------------------------
// rotary_encoder_decoder: debounced quadrature encoder with push button
//
// Input channel (in_valid/in_ready/in_data): each word is either a poll tick
// carrying the raw A, B and push levels (mode 0) or a request to consume the
// pending event (mode 1). Output channel (out_valid/out_ready/out_data): one
// word per input word, carrying the consumed event (idle on ticks) and the
// clean pin levels after that word.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 enable, 1 debounce reload); write only while the block is idle.
// Path: a word accepted into the input register is worked on from there and
// lands in the result register once that register is free or being taken.
// Throughput: one word per cycle while the result register is not stalled,
// set by the single pass from input register through debouncers and table
// lookup to the result register.
// Stall: while out_ready is low the result register holds; one further word
// waits in the input register, after which in_ready drops.
// Reset: enable off, reload 4, clean pins low, phase at start, nothing
// pending, both registers empty.
// ----------------------------------------------------------------------------
module rotary_encoder_decoder #(
    parameter int TIMER_WIDTH = rotenc_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  rotenc_pkg::in_word_t                   in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output rotenc_pkg::out_word_t                  out_data,
    input  logic                                   cfg_we,
    input  logic [rotenc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rotenc_pkg::CFG_WIDTH-1:0]       cfg_data
);

    // configuration registers
    logic                            enable_reg;
    logic [rotenc_pkg::CFG_WIDTH-1:0] debounce_reg;
    logic [TIMER_WIDTH-1:0]           reload;

    // input register
    logic                 in_valid_reg;
    rotenc_pkg::in_word_t in_word_reg;

    // result register
    logic                  out_valid_reg;
    rotenc_pkg::out_word_t out_word_reg;
    rotenc_pkg::out_word_t out_word_next;

    logic                  advance;
    rotenc_pkg::step_ctl_t ctl;
    logic                  clean_a_next;
    logic                  clean_b_next;
    logic                  clean_push_next;
    logic [1:0]            pending;

    // advance the held word when the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign ctl.consume = advance && (in_word_reg.mode == rotenc_pkg::MODE_CONSUME);
    assign ctl.tick    = advance && (in_word_reg.mode == rotenc_pkg::MODE_TICK) && enable_reg;

    // reload truncates or zero-extends to the timer width
    assign reload = TIMER_WIDTH'(debounce_reg);

    rotenc_debounce #(.TIMER_WIDTH(TIMER_WIDTH)) u_deb_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (ctl.tick),
        .raw        (in_word_reg.pin_a),
        .reload     (reload),
        .clean_next (clean_a_next)
    );

    rotenc_debounce #(.TIMER_WIDTH(TIMER_WIDTH)) u_deb_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (ctl.tick),
        .raw        (in_word_reg.pin_b),
        .reload     (reload),
        .clean_next (clean_b_next)
    );

    rotenc_debounce #(.TIMER_WIDTH(TIMER_WIDTH)) u_deb_push (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (ctl.tick),
        .raw        (in_word_reg.pin_push),
        .reload     (reload),
        .clean_next (clean_push_next)
    );

    rotenc_quad u_quad (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .clean_a    (clean_a_next),
        .clean_b    (clean_b_next),
        .clean_push (clean_push_next),
        .pending    (pending)
    );

    // a consume returns what was pending before this word; ticks report idle
    always_comb
    begin
        out_word_next.event_res  = ctl.consume ? pending : rotenc_pkg::EV_IDLE;
        out_word_next.clean_a    = clean_a_next;
        out_word_next.clean_b    = clean_b_next;
        out_word_next.clean_push = clean_push_next;
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            debounce_reg  <= rotenc_pkg::DEBOUNCE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rotenc_pkg::REG_ENABLE:   enable_reg   <= cfg_data[0];
                    rotenc_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data;
                    default:                  ;
                endcase
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: hold unless a new word moves in
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_data;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the debounced rotary encoder decoder
// Drives poll ticks and consume requests through the input channel, predicts
// every output word from a local model of the debouncers, the detent table
// and the pending event, and compares each output word field by field.
// ----------------------------------------------------------------------------
module tb_top;

    // longest run of cycles with no word moving before the run is abandoned
    localparam int STALL_LIMIT = 2000;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_ready;
    rotenc_pkg::in_word_t                   in_data = '0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    rotenc_pkg::out_word_t                  out_data;
    logic                                   cfg_we = 1'b0;
    logic [rotenc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [rotenc_pkg::CFG_WIDTH-1:0]       cfg_data = '0;

    // next phase and event of one detent table entry
    typedef struct packed {
        logic [2:0] nxt;
        logic [1:0] ev;
    } detent_cell_t;

    // local copy of the decoder state and its registers
    logic                             mdl_enable;
    logic [rotenc_pkg::CFG_WIDTH-1:0] mdl_reload;
    logic [2:0]                       mdl_clean;      // A bit 0, B bit 1, push bit 2
    logic [15:0]                      mdl_timer [3];
    logic [2:0]                       mdl_phase;
    logic [1:0]                       mdl_event;

    rotenc_pkg::out_word_t awaited_words [$];
    int        mismatch_count = 0;
    int        words_sent = 0;
    int        words_checked = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      last_a = 1'b0;
    logic      last_b = 1'b0;

    rotary_encoder_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Detent table: rest is A and B high. Clockwise runs through A only, both
    // low, B only and back to rest; counter-clockwise mirrors it. Every entry
    // not listed, the unused phase seven among them, falls back to start.
    function automatic detent_cell_t detent_lookup(input logic [2:0] ph,
                                                   input logic [1:0] col);
        detent_cell_t c;
        c.nxt = rotenc_pkg::PH_START;
        c.ev  = rotenc_pkg::EV_IDLE;
        case ({ph, col})
            {rotenc_pkg::PH_START, 2'd1}:     c.nxt = rotenc_pkg::PH_CW_BEGIN;
            {rotenc_pkg::PH_START, 2'd2}:     c.nxt = rotenc_pkg::PH_CCW_BEGIN;
            {rotenc_pkg::PH_CW_BEGIN, 2'd0}:  c.nxt = rotenc_pkg::PH_CW_NEXT;
            {rotenc_pkg::PH_CW_BEGIN, 2'd1}:  c.nxt = rotenc_pkg::PH_CW_BEGIN;
            {rotenc_pkg::PH_CW_NEXT, 2'd0}:   c.nxt = rotenc_pkg::PH_CW_NEXT;
            {rotenc_pkg::PH_CW_NEXT, 2'd1}:   c.nxt = rotenc_pkg::PH_CW_BEGIN;
            {rotenc_pkg::PH_CW_NEXT, 2'd2}:   c.nxt = rotenc_pkg::PH_CW_FINAL;
            {rotenc_pkg::PH_CW_FINAL, 2'd0}:  c.nxt = rotenc_pkg::PH_CW_NEXT;
            {rotenc_pkg::PH_CW_FINAL, 2'd2}:  c.nxt = rotenc_pkg::PH_CW_FINAL;
            {rotenc_pkg::PH_CW_FINAL, 2'd3}:  c.ev  = rotenc_pkg::EV_CW;
            {rotenc_pkg::PH_CCW_BEGIN, 2'd0}: c.nxt = rotenc_pkg::PH_CCW_NEXT;
            {rotenc_pkg::PH_CCW_BEGIN, 2'd2}: c.nxt = rotenc_pkg::PH_CCW_BEGIN;
            {rotenc_pkg::PH_CCW_NEXT, 2'd0}:  c.nxt = rotenc_pkg::PH_CCW_NEXT;
            {rotenc_pkg::PH_CCW_NEXT, 2'd1}:  c.nxt = rotenc_pkg::PH_CCW_FINAL;
            {rotenc_pkg::PH_CCW_NEXT, 2'd2}:  c.nxt = rotenc_pkg::PH_CCW_BEGIN;
            {rotenc_pkg::PH_CCW_FINAL, 2'd0}: c.nxt = rotenc_pkg::PH_CCW_NEXT;
            {rotenc_pkg::PH_CCW_FINAL, 2'd1}: c.nxt = rotenc_pkg::PH_CCW_FINAL;
            {rotenc_pkg::PH_CCW_FINAL, 2'd3}: c.ev  = rotenc_pkg::EV_CCW;
            default:                          c.nxt = rotenc_pkg::PH_START;
        endcase
        return c;
    endfunction

    // Advance the local state by one accepted input word and give the output
    // word that the block must return for it.
    task automatic decode_word(input rotenc_pkg::in_word_t w,
                               output rotenc_pkg::out_word_t r);
        detent_cell_t entry;
        logic [2:0]   raw;
        int           i;
        r = '0;
        r.event_res = rotenc_pkg::EV_IDLE;
        if (w.mode == rotenc_pkg::MODE_CONSUME)
        begin
            r.event_res = mdl_event;
            mdl_event   = rotenc_pkg::EV_IDLE;
        end
        else if (mdl_enable)
        begin
            raw = {w.pin_push, w.pin_b, w.pin_a};
            for (i = 0; i < 3; i++)
            begin
                // reload while matching, count down while differing, flip at zero
                if (raw[i] == mdl_clean[i])
                    mdl_timer[i] = mdl_reload;
                else if (mdl_timer[i] == '0)
                begin
                    mdl_clean[i] = raw[i];
                    mdl_timer[i] = mdl_reload;
                end
                else
                    mdl_timer[i] = mdl_timer[i] - 16'd1;
            end
            // a held push overrides anything pending
            if (mdl_clean[2])
                mdl_event = rotenc_pkg::EV_PUSH;
            entry     = detent_lookup(mdl_phase, mdl_clean[1:0]);
            mdl_phase = entry.nxt;
            // a rotation is dropped while another event waits
            if (mdl_event == rotenc_pkg::EV_IDLE)
                mdl_event = entry.ev;
        end
        r.clean_a    = mdl_clean[0];
        r.clean_b    = mdl_clean[1];
        r.clean_push = mdl_clean[2];
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at output word %0d: %s", words_checked, what);
        mismatch_count++;
    endtask

    task automatic check_word(input rotenc_pkg::out_word_t got);
        rotenc_pkg::out_word_t want;
        if (awaited_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h", got));
            return;
        end
        want = awaited_words.pop_front();
        if (got.event_res !== want.event_res)
            report_mismatch($sformatf("event_res %0d, want %0d", got.event_res, want.event_res));
        if (got.clean_a !== want.clean_a)
            report_mismatch($sformatf("clean_a %b, want %b", got.clean_a, want.clean_a));
        if (got.clean_b !== want.clean_b)
            report_mismatch($sformatf("clean_b %b, want %b", got.clean_b, want.clean_b));
        if (got.clean_push !== want.clean_push)
            report_mismatch($sformatf("clean_push %b, want %b",
                                      got.clean_push, want.clean_push));
        words_checked++;
    endtask

    // Output side: stall at random and check every word taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_word(out_data);
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: abandon the run once nothing has moved for too long.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Write one register; the block must be idle. Drop the write enable
    // afterwards so that back-to-back writes stay one assignment a step.
    task automatic write_reg(input logic [rotenc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [rotenc_pkg::CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == rotenc_pkg::REG_ENABLE)
            mdl_enable = value[0];
        else if (idx == rotenc_pkg::REG_DEBOUNCE)
            mdl_reload = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one word, idling first at random; return at the edge that takes it.
    task automatic send_word(input rotenc_pkg::in_word_t w);
        rotenc_pkg::out_word_t want;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_word(w, want);
        awaited_words.push_back(want);
        words_sent++;
    endtask

    task automatic send_tick(input logic a, input logic b, input logic p);
        rotenc_pkg::in_word_t w;
        w.mode     = rotenc_pkg::MODE_TICK;
        w.pin_a    = a;
        w.pin_b    = b;
        w.pin_push = p;
        last_a     = a;
        last_b     = b;
        send_word(w);
    endtask

    task automatic send_consume();
        rotenc_pkg::in_word_t w;
        w          = rotenc_pkg::in_word_t'(4'($urandom_range(0, 7)));
        w.mode     = rotenc_pkg::MODE_CONSUME;
        send_word(w);
    endtask

    // Drop valid, wait for every awaited word, then let the pipeline settle.
    task automatic drain_words();
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Ticks while disabled change nothing; consume with nothing pending.
    task automatic test_disabled_ticks();
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_consume();
        drain_words();
    endtask

    // One clockwise and one counter-clockwise detent, then a push that
    // swallows a later rotation.
    task automatic test_detent_events();
        write_reg(rotenc_pkg::REG_ENABLE, 16'd1);
        write_reg(rotenc_pkg::REG_DEBOUNCE, 16'd0);
        // reload the timers from their reset count
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_consume();
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_consume();
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_consume();
        drain_words();
    endtask

    // A push latched while enabled is still handed out once disabled.
    task automatic test_consume_disabled();
        send_tick(1'b1, 1'b1, 1'b1);
        drain_words();
        write_reg(rotenc_pkg::REG_ENABLE, 16'd0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_consume();
        send_consume();
        drain_words();
    endtask

    // Widest reload: timers already at zero flip at once and then reload to
    // the new count, so later differing ticks only count down.
    task automatic test_slow_debounce();
        write_reg(rotenc_pkg::REG_ENABLE, 16'd1);
        write_reg(rotenc_pkg::REG_DEBOUNCE, 16'hFFFF);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_consume();
        drain_words();
    endtask

    // Random traffic, mostly whole detents held long enough to pass the
    // debouncers, mixed with consumes, pushes, glitches and raw noise.
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input logic [rotenc_pkg::CFG_WIDTH-1:0] reload,
                                       input int n_words);
        int         first;
        int         pick;
        int         hold;
        int         k;
        int         j;
        logic [7:0] levels;
        logic [1:0] col;
        write_reg(rotenc_pkg::REG_ENABLE, 16'd1);
        write_reg(rotenc_pkg::REG_DEBOUNCE, reload);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        first = words_sent;
        while (words_sent - first < n_words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // levels in order, last one is the rest position
                levels = $urandom_range(0, 1) ? 8'b11_10_00_01 : 8'b11_01_00_10;
                for (k = 0; k < 4; k++)
                begin
                    col = levels[2*k +: 2];
                    if ($urandom_range(0, 11) == 0)
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
                    if ($urandom_range(0, 9) == 0)
                        hold = $urandom_range(1, int'(mdl_reload) + 1);
                    else
                        hold = int'(mdl_reload) + 1 + $urandom_range(0, 2);
                    for (j = 0; j < hold; j++)
                        send_tick(col[0], col[1], ($urandom_range(0, 19) == 0));
                end
            end
            else if (pick < 75)
                send_consume();
            else if (pick < 85)
            begin
                hold = int'(mdl_reload) + 1 + $urandom_range(0, 3);
                for (j = 0; j < hold; j++)
                    send_tick(last_a, last_b, 1'b1);
                for (j = 0; j <= int'(mdl_reload); j++)
                    send_tick(last_a, last_b, 1'b0);
            end
            else
            begin
                hold = $urandom_range(1, 4);
                for (j = 0; j < hold; j++)
                    send_word(rotenc_pkg::in_word_t'(4'($urandom_range(0, 15))));
            end
        end
        drain_words();
    endtask

    initial
    begin
        // state after reset
        mdl_enable = 1'b0;
        mdl_reload = rotenc_pkg::DEBOUNCE_RESET;
        mdl_clean  = 3'b000;
        for (int i = 0; i < 3; i++)
            mdl_timer[i] = rotenc_pkg::DEBOUNCE_RESET;
        mdl_phase  = rotenc_pkg::PH_START;
        mdl_event  = rotenc_pkg::EV_IDLE;

        send_idle_pct = 15;
        recv_idle_pct = 61;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_ticks();
        test_detent_events();
        test_consume_disabled();
        test_slow_debounce();
        test_random_traffic(15, 61, 16'd0, 450);
        test_random_traffic(61, 15, 16'($urandom_range(1, 3)), 450);
        test_random_traffic(0, 0, 16'd2, 450);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
src/rotenc_pkg.sv
src/rotenc_debounce.sv
src/rotenc_quad.sv
src/rotary_encoder_decoder.sv
verif/tb_top.sv
